### rtl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared widths, register codes and reset values for the video capture
// sync decoder.
// ----------------------------------------------------------------------------
package vsc_pkg;

   localparam int COUNT_BITS_DEF = 13;

   localparam int COORD_W  = 12;
   localparam int PORCH_W  = 10;
   localparam int COLOUR_W = 8;
   localparam int DEPTH_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // end of window, back porch plus active size, always fits here
   localparam int END_W = 13;

   localparam logic [COORD_W-1:0] H_ACTIVE_RST     = 12'd640;
   localparam logic [PORCH_W-1:0] H_BACK_PORCH_RST = 10'd48;
   localparam logic [COORD_W-1:0] V_ACTIVE_RST     = 12'd480;
   localparam logic [PORCH_W-1:0] V_BACK_PORCH_RST = 10'd33;
   localparam logic [DEPTH_W-1:0] COLOR_BITS_RST   = 4'd6;

   localparam logic [DEPTH_W-1:0] FULL_DEPTH = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_H_ACTIVE     = 3'd0,
      CSR_H_BACK_PORCH = 3'd1,
      CSR_V_ACTIVE     = 3'd2,
      CSR_V_BACK_PORCH = 3'd3,
      CSR_COLOR_BITS   = 3'd4
   } csr_index_type;

endpackage

### rtl/vga_sync_pixel_capture.sv
// ----------------------------------------------------------------------------
// vga_sync_pixel_capture
// Decodes active-low sync levels into line and frame position and emits
// one pixel write beat, scaled to 8-bit colour, for every sample taken.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | sync levels, rgb sample
//  rsp     | out       | rsp_valid/rsp_stall | pixel write, frame and line flags
//  csr     | in        | csr_valid/csr_ready | register index, write data
//
//  one sample per cycle unless rsp is stalled: a beat taken at an edge is registered there and shows at rsp
//  the counters and the result register are the only state on the path
//  reset clears the counters, loads register defaults and empties rsp
//  req_stall is high only while a result is held and rsp_stall is high
// ----------------------------------------------------------------------------
module vga_sync_pixel_capture #(
   parameter int COUNT_BITS = vsc_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_vsync_level,
   input  logic                           req_hsync_level,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_red_in,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_green_in,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_blue_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pixel_valid,
   output logic [vsc_pkg::COORD_W-1:0]    rsp_pixel_x,
   output logic [vsc_pkg::COORD_W-1:0]    rsp_pixel_y,
   output logic [vsc_pkg::COLOUR_W-1:0]   rsp_red_out,
   output logic [vsc_pkg::COLOUR_W-1:0]   rsp_green_out,
   output logic [vsc_pkg::COLOUR_W-1:0]   rsp_blue_out,
   output logic                           rsp_frame_done,
   output logic                           rsp_line_advanced,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsc_pkg::CSR_DATA_W-1:0] csr_data
);
   import vsc_pkg::*;

   localparam int CMP_W = (COUNT_BITS > END_W) ? COUNT_BITS : END_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // configuration registers
   logic [COORD_W-1:0] h_active_ff;
   logic [PORCH_W-1:0] h_back_porch_ff;
   logic [COORD_W-1:0] v_active_ff;
   logic [PORCH_W-1:0] v_back_porch_ff;
   logic [DEPTH_W-1:0] color_bits_ff;

   logic [COUNT_BITS-1:0] h_count_ff, h_count_in;
   logic [COUNT_BITS-1:0] v_count_ff, v_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                pixel_valid_ff, pixel_valid_in;
   logic [COORD_W-1:0]  pixel_x_ff, pixel_x_in;
   logic [COORD_W-1:0]  pixel_y_ff, pixel_y_in;
   logic [COLOUR_W-1:0] red_ff, red_in;
   logic [COLOUR_W-1:0] green_ff, green_in;
   logic [COLOUR_W-1:0] blue_ff, blue_in;
   logic                frame_done_ff, frame_done_in;
   logic                line_ff, line_in;

   logic                  take;
   logic [COUNT_BITS-1:0] hc, vc;
   logic [CMP_W-1:0]      hc_w, vc_w, h_next_w;
   logic [CMP_W-1:0]      h_bp_w, v_bp_w, h_end_w, v_end_w;
   logic                  active;
   logic [CMP_W-1:0]      x_diff, y_diff;
   logic [END_W-1:0]      x_inc, y_inc;
   logic [DEPTH_W-1:0]    depth, shift;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_active_ff     <= H_ACTIVE_RST;
         h_back_porch_ff <= H_BACK_PORCH_RST;
         v_active_ff     <= V_ACTIVE_RST;
         v_back_porch_ff <= V_BACK_PORCH_RST;
         color_bits_ff   <= COLOR_BITS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_H_ACTIVE:     h_active_ff     <= csr_data[COORD_W-1:0];
            CSR_H_BACK_PORCH: h_back_porch_ff <= csr_data[PORCH_W-1:0];
            CSR_V_ACTIVE:     v_active_ff     <= csr_data[COORD_W-1:0];
            CSR_V_BACK_PORCH: v_back_porch_ff <= csr_data[PORCH_W-1:0];
            CSR_COLOR_BITS:   color_bits_ff   <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      // sync low clears the counter before the window test
      hc = req_hsync_level ? h_count_ff : '0;
      vc = req_vsync_level ? v_count_ff : '0;

      hc_w    = CMP_W'(hc);
      vc_w    = CMP_W'(vc);
      h_bp_w  = CMP_W'(h_back_porch_ff);
      v_bp_w  = CMP_W'(v_back_porch_ff);
      h_end_w = CMP_W'(h_back_porch_ff) + CMP_W'(h_active_ff);
      v_end_w = CMP_W'(v_back_porch_ff) + CMP_W'(v_active_ff);

      active = (vc_w >= v_bp_w) && (vc_w < v_end_w) &&
               (hc_w >= h_bp_w) && (hc_w < h_end_w);

      x_diff = hc_w - h_bp_w;
      y_diff = vc_w - v_bp_w;
      x_inc  = END_W'(x_diff[COORD_W-1:0]) + END_W'(1);
      y_inc  = END_W'(y_diff[COORD_W-1:0]) + END_W'(1);

      depth = (color_bits_ff > FULL_DEPTH) ? FULL_DEPTH : color_bits_ff;
      shift = FULL_DEPTH - depth;

      pixel_valid_in = active;
      if (active) begin
         pixel_x_in    = x_diff[COORD_W-1:0];
         pixel_y_in    = y_diff[COORD_W-1:0];
         red_in        = req_red_in << shift;
         green_in      = req_green_in << shift;
         blue_in       = req_blue_in << shift;
         frame_done_in = (x_inc == END_W'(h_active_ff)) &&
                         (y_inc == END_W'(v_active_ff));
      end else begin
         pixel_x_in    = '0;
         pixel_y_in    = '0;
         red_in        = '0;
         green_in      = '0;
         blue_in       = '0;
         frame_done_in = 1'b0;
      end

      // saturating advance, line flag uses the new horizontal count
      h_count_in = (req_hsync_level && (hc != CNT_MAX)) ? hc + COUNT_BITS'(1) : hc;
      h_next_w   = CMP_W'(h_count_in);
      line_in    = req_vsync_level && (h_next_w == h_end_w);
      v_count_in = (line_in && (vc != CNT_MAX)) ? vc + COUNT_BITS'(1) : vc;

      rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_count_ff   <= '0;
         v_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            h_count_ff <= h_count_in;
            v_count_ff <= v_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pixel_valid_ff <= pixel_valid_in;
         pixel_x_ff     <= pixel_x_in;
         pixel_y_ff     <= pixel_y_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
         blue_ff        <= blue_in;
         frame_done_ff  <= frame_done_in;
         line_ff        <= line_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_valid   = pixel_valid_ff;
   assign rsp_pixel_x       = pixel_x_ff;
   assign rsp_pixel_y       = pixel_y_ff;
   assign rsp_red_out       = red_ff;
   assign rsp_green_out     = green_ff;
   assign rsp_blue_out      = blue_ff;
   assign rsp_frame_done    = frame_done_ff;
   assign rsp_line_advanced = line_ff;

endmodule

### tb/vga_sync_pixel_capture_checker.sv
// ----------------------------------------------------------------------------
// vga_sync_pixel_capture_checker
// Watches the sample, pixel and register channels of the capture sync
// decoder. It keeps its own line and frame counters and register copies,
// predicts one pixel write beat per sample taken and compares every field.
// ----------------------------------------------------------------------------
module vga_sync_pixel_capture_checker #(
   parameter int COUNT_BITS = vsc_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_vsync_level,
   input  logic                           req_hsync_level,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_red_in,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_green_in,
   input  logic [vsc_pkg::COLOUR_W-1:0]   req_blue_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_pixel_valid,
   input  logic [vsc_pkg::COORD_W-1:0]    rsp_pixel_x,
   input  logic [vsc_pkg::COORD_W-1:0]    rsp_pixel_y,
   input  logic [vsc_pkg::COLOUR_W-1:0]   rsp_red_out,
   input  logic [vsc_pkg::COLOUR_W-1:0]   rsp_green_out,
   input  logic [vsc_pkg::COLOUR_W-1:0]   rsp_blue_out,
   input  logic                           rsp_frame_done,
   input  logic                           rsp_line_advanced,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [vsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatches,
   output int                             pending
);
   import vsc_pkg::*;

   localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic                pixel_valid;
      logic [COORD_W-1:0]  pixel_x;
      logic [COORD_W-1:0]  pixel_y;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                frame_done;
      logic                line_advanced;
   } pixel_write_type;

   pixel_write_type pixel_queue[$];

   logic [COUNT_BITS-1:0] h_count;
   logic [COUNT_BITS-1:0] v_count;
   logic [COORD_W-1:0]    h_active;
   logic [PORCH_W-1:0]    h_porch;
   logic [COORD_W-1:0]    v_active;
   logic [PORCH_W-1:0]    v_porch;
   logic [DEPTH_W-1:0]    colour_depth;
   int                    beat_no;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_LIMIT) begin
         $display("ERROR: pixel beat %0d: %s is %0d, expected %0d",
                  beat_no, field, got, want);
      end
      mismatches++;
   endtask

   function automatic logic [COLOUR_W-1:0] scale_colour(input logic [COLOUR_W-1:0] c,
                                                        input int unsigned shift);
      int unsigned wide;
      wide = c;
      return COLOUR_W'(wide << shift);
   endfunction

   // one pixel clock edge: clear on sync, test the window, then count
   task automatic decode_sample(input logic vs, input logic hs,
                                input logic [COLOUR_W-1:0] r, input logic [COLOUR_W-1:0] g,
                                input logic [COLOUR_W-1:0] b, output pixel_write_type pw);
      int unsigned h_end;
      int unsigned v_end;
      int unsigned shift;
      int unsigned x;
      int unsigned y;
      h_end = h_porch + h_active;
      v_end = v_porch + v_active;
      shift = (colour_depth > FULL_DEPTH) ? 0 : FULL_DEPTH - colour_depth;
      pw = '0;
      if (!hs) h_count = '0;
      if (!vs) v_count = '0;
      if (v_count >= v_porch && v_count < v_end && h_count >= h_porch && h_count < h_end) begin
         x = h_count - h_porch;
         y = v_count - v_porch;
         pw.pixel_valid = 1'b1;
         pw.pixel_x     = COORD_W'(x);
         pw.pixel_y     = COORD_W'(y);
         pw.red         = scale_colour(r, shift);
         pw.green       = scale_colour(g, shift);
         pw.blue        = scale_colour(b, shift);
         pw.frame_done  = (x + 1 == h_active) && (y + 1 == v_active);
      end
      if (hs && h_count < COUNT_MAX) h_count++;
      // the flag holds even once the row counter has stopped
      if (vs && h_count == h_end) begin
         pw.line_advanced = 1'b1;
         if (v_count < COUNT_MAX) v_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_write_type seen;
      pixel_write_type want;
      if (reset) begin
         h_count      = '0;
         v_count      = '0;
         h_active     = H_ACTIVE_RST;
         h_porch      = H_BACK_PORCH_RST;
         v_active     = V_ACTIVE_RST;
         v_porch      = V_BACK_PORCH_RST;
         colour_depth = COLOR_BITS_RST;
         beat_no      = 0;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_pixel_valid, rsp_pixel_x, rsp_pixel_y, rsp_red_out, rsp_green_out,
                    rsp_blue_out, rsp_frame_done, rsp_line_advanced};
            if (pixel_queue.size() == 0) begin
               report_mismatch("beat with nothing outstanding", 1, 0);
            end else begin
               want = pixel_queue.pop_front();
               if (seen.pixel_valid !== want.pixel_valid)
                  report_mismatch("pixel_valid", seen.pixel_valid, want.pixel_valid);
               if (seen.pixel_x !== want.pixel_x)
                  report_mismatch("pixel_x", seen.pixel_x, want.pixel_x);
               if (seen.pixel_y !== want.pixel_y)
                  report_mismatch("pixel_y", seen.pixel_y, want.pixel_y);
               if (seen.red !== want.red)
                  report_mismatch("red_out", seen.red, want.red);
               if (seen.green !== want.green)
                  report_mismatch("green_out", seen.green, want.green);
               if (seen.blue !== want.blue)
                  report_mismatch("blue_out", seen.blue, want.blue);
               if (seen.frame_done !== want.frame_done)
                  report_mismatch("frame_done", seen.frame_done, want.frame_done);
               if (seen.line_advanced !== want.line_advanced)
                  report_mismatch("line_advanced", seen.line_advanced, want.line_advanced);
            end
            beat_no++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_H_ACTIVE:     h_active     = csr_data[COORD_W-1:0];
               CSR_H_BACK_PORCH: h_porch      = csr_data[PORCH_W-1:0];
               CSR_V_ACTIVE:     v_active     = csr_data[COORD_W-1:0];
               CSR_V_BACK_PORCH: v_porch      = csr_data[PORCH_W-1:0];
               CSR_COLOR_BITS:   colour_depth = csr_data[DEPTH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            decode_sample(req_vsync_level, req_hsync_level, req_red_in, req_green_in,
                          req_blue_in, want);
            pixel_queue.push_back(want);
         end
      end
      pending = pixel_queue.size();
   end

endmodule

### tb/tb_vga_sync_pixel_capture.sv
// ----------------------------------------------------------------------------
// tb_vga_sync_pixel_capture
// Drives sync levels and colour samples into the capture sync decoder as
// small frames under changing window settings. The checker beside the
// block does the prediction; this module makes the stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_vga_sync_pixel_capture;
   import vsc_pkg::*;

   localparam int RUN_LIMIT_CYCLES = 1_000_000;
   localparam int WINDOW_SAMPLES   = 50;
   localparam int CSR_SPARE_LO     = int'(CSR_COLOR_BITS) + 1;
   localparam int CSR_SPARE_HI     = (1 << CSR_IDX_W) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_vsync_level;
   logic                  req_hsync_level;
   logic [COLOUR_W-1:0]   req_red_in;
   logic [COLOUR_W-1:0]   req_green_in;
   logic [COLOUR_W-1:0]   req_blue_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_pixel_valid;
   logic [COORD_W-1:0]    rsp_pixel_x;
   logic [COORD_W-1:0]    rsp_pixel_y;
   logic [COLOUR_W-1:0]   rsp_red_out;
   logic [COLOUR_W-1:0]   rsp_green_out;
   logic [COLOUR_W-1:0]   rsp_blue_out;
   logic                  rsp_frame_done;
   logic                  rsp_line_advanced;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatches;
   int pending;
   int req_idle_pct  = 37;
   int rsp_stall_pct = 65;
   int samples_sent  = 0;
   int window_no     = 0;
   int cur_h_active;
   int cur_h_porch;
   int cur_v_active;
   int cur_v_porch;

   vga_sync_pixel_capture uut (.*);

   vga_sync_pixel_capture_checker pixel_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      #(10 * RUN_LIMIT_CYCLES);
      $display("vga_sync_pixel_capture: mismatch");
      $finish;
   end

   task automatic send_sample(input logic vs, input logic hs, input logic [COLOUR_W-1:0] r,
                              input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_vsync_level <= vs;
      req_hsync_level <= hs;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic send_sync(input logic vs, input logic hs);
      send_sample(vs, hs, COLOUR_W'($urandom), COLOUR_W'($urandom), COLOUR_W'($urandom));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_window(input int ha, input int hbp, input int va, input int vbp,
                             input int depth);
      // junk above the width of the narrow registers must be dropped
      write_csr(CSR_H_ACTIVE, CSR_DATA_W'(ha));
      write_csr(CSR_H_BACK_PORCH, CSR_DATA_W'(hbp | ($urandom_range(3) << PORCH_W)));
      write_csr(CSR_V_ACTIVE, CSR_DATA_W'(va));
      write_csr(CSR_V_BACK_PORCH, CSR_DATA_W'(vbp | ($urandom_range(3) << PORCH_W)));
      write_csr(CSR_COLOR_BITS, CSR_DATA_W'(depth | ($urandom_range(255) << DEPTH_W)));
      if ($urandom_range(2) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                   CSR_DATA_W'($urandom));
      csr_valid    <= 1'b0;
      cur_h_active = ha;
      cur_h_porch  = hbp;
      cur_v_active = va;
      cur_v_porch  = vbp;
   endtask

   // hold samples back until every pixel beat is out and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_frame();
      int lines;
      int span;
      lines = cur_v_porch + cur_v_active + $urandom_range(1);
      repeat ($urandom_range(2, 1)) send_sync(1'b0, 1'($urandom_range(1)));
      repeat (lines) begin
         repeat ($urandom_range(2, 1)) send_sync(1'b1, 1'b0);
         span = cur_h_porch + cur_h_active + $urandom_range(2);
         // now and then a line cut short, or a stray sample
         if ($urandom_range(9) == 0) span = $urandom_range(span);
         repeat (span) send_sync(1'b1, 1'b1);
         if ($urandom_range(9) == 0)
            send_sync(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   task automatic random_windows(input int quota);
      int upto;
      int window_start;
      upto = samples_sent + quota;
      while (samples_sent < upto) begin
         drain();
         // first windows hit the zero and oversized depths and empty axes
         set_window(window_no == 2 ? 0 : $urandom_range(6, 1), $urandom_range(3),
                    window_no == 3 ? 0 : $urandom_range(4, 1), $urandom_range(2),
                    window_no == 0 ? 0 : window_no == 1 ? 15 : $urandom_range(15));
         window_no++;
         window_start = samples_sent;
         while (samples_sent - window_start < WINDOW_SAMPLES) send_frame();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_vsync_level = 1'b1;
      req_hsync_level = 1'b1;
      req_red_in      = '0;
      req_green_in    = '0;
      req_blue_in     = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_H_ACTIVE;
      csr_data        = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // tiny window at full depth: porch columns, one porch row, last pixel
      set_window(3, 1, 2, 1, FULL_DEPTH);
      send_sample(1'b0, 1'b0, '0, '0, '0);
      send_sample(1'b1, 1'b0, {COLOUR_W{1'b1}}, {COLOUR_W{1'b1}}, {COLOUR_W{1'b1}});
      for (int line = 0; line < 3; line++) begin
         send_sample(1'b1, 1'b0, '0, {COLOUR_W{1'b1}}, '0);
         for (int col = 0; col < 4; col++) begin
            send_sample(1'b1, 1'b1, {COLOUR_W{col[0]}}, {COLOUR_W{~col[0]}},
                        COLOUR_W'($urandom));
         end
      end

      random_windows(233);
      req_idle_pct  = 65;
      rsp_stall_pct = 37;
      random_windows(233);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;

      random_windows(234);
      drain();

      if (mismatches == 0 && pending == 0) begin
         $display("vga_sync_pixel_capture: match");
      end else begin
         $display("vga_sync_pixel_capture: mismatch");
      end
      $finish;
   end

endmodule
